// ----- hdl/lps_pkg.sv -----
// Shared types and constants for the LRU page replacement stack.
// Holds the cell control and status structs and the fixed field widths.
// No dependencies; every other file imports this package.
package lps_pkg;

    localparam int CFG_W   = 5;
    localparam int DEPTH_W = 4;
    localparam int OCC_W   = 5;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

    // Per-cell control from the top level for the compare/shift cycle.
    typedef struct packed {
        logic resident;
        logic shift;
    } cell_ctrl_t;

    // Per-cell status; hit_out ripples down the chain to the next cell.
    typedef struct packed {
        logic first;
        logic hit_out;
    } cell_stat_t;

endpackage

// ----- hdl/lps_cell.sv -----
// One stack position of the LRU page replacement stack.
// Holds a page number, compares it with the referenced page and takes its
// upper neighbor's entry when told to shift. Depends on lps_pkg.
module lps_cell #(
    parameter int PAGE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic [PAGE_WIDTH-1:0] page,
    input  logic [PAGE_WIDTH-1:0] left,
    input  lps_pkg::cell_ctrl_t   ctrl,
    input  logic                  hit_in,
    output logic [PAGE_WIDTH-1:0] entry,
    output lps_pkg::cell_stat_t   stat
);
    import lps_pkg::*;

    logic [PAGE_WIDTH-1:0] entry_reg;
    logic [PAGE_WIDTH-1:0] entry_next;
    logic                  match;

    assign match = ctrl.resident && (entry_reg == page);

    // Only the topmost matching cell is the hit; cells below see hit_in set.
    assign stat.first   = match && !hit_in;
    assign stat.hit_out = match || hit_in;

    assign entry_next = ctrl.shift ? left : entry_reg;
    assign entry      = entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hdl/lru_page_replacement_stack.sv -----
// LRU stack page replacement: a chain of cells, most recent page on top.
// start is registered into busy and busy into done; busy is high for the
// one compare/shift cycle, and no new page is accepted while busy is high.
// In that cycle the cells compare and shift down to the hit or stack end.
// Reset clears occupancy, the fault total and sets the frame limit to 16;
// stack entries are not cleared.
module lru_page_replacement_stack #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [PAGE_WIDTH-1:0]         page_number,
    input  logic                          cfg_we,
    input  logic [lps_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic                          page_fault,
    output logic [lps_pkg::DEPTH_W-1:0]   hit_depth,
    output logic                          evict_valid,
    output logic [PAGE_WIDTH-1:0]         evicted_page,
    output logic [lps_pkg::OCC_W-1:0]     occupancy,
    output logic [lps_pkg::FAULT_W-1:0]   fault_total
);
    import lps_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic                  act_reg, act_next;
    logic                  done_reg, done_next;
    logic [PAGE_WIDTH-1:0] page_reg, page_next;
    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FAULT_W-1:0]    fault_cnt_reg, fault_cnt_next;
    logic                  fault_reg, fault_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic                  evict_reg, evict_next;
    logic [PAGE_WIDTH-1:0] ev_page_reg, ev_page_next;

    logic [PAGE_WIDTH-1:0] entry_w [MAX_FRAMES];
    cell_ctrl_t            ctrl_w  [MAX_FRAMES];
    cell_stat_t            stat_w  [MAX_FRAMES];

    logic                  accept;
    logic                  hit;
    logic                  evict;
    logic [CNT_W-1:0]      pos;
    logic [CMP_W-1:0]      limit;
    logic [CNT_W-1:0]      cnt_kept;
    logic [CNT_W-1:0]      shift_lim;
    logic [PAGE_WIDTH-1:0] bottom_page;

    assign accept = start && !act_reg;

    // The cell chain; cell 0 loads the referenced page whenever it shifts.
    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        logic [PAGE_WIDTH-1:0] left_w;
        logic                  hit_in_w;

        if (i == 0) begin : g_top
            assign left_w   = page_reg;
            assign hit_in_w = 1'b0;
        end else begin : g_below
            assign left_w   = entry_w[i-1];
            assign hit_in_w = stat_w[i-1].hit_out;
        end

        assign ctrl_w[i].resident = CNT_W'(i) < count_reg;
        assign ctrl_w[i].shift    = act_reg && ((i == 0) || (CNT_W'(i) <= shift_lim));

        lps_cell #(
            .PAGE_WIDTH(PAGE_WIDTH)
        ) u_cell (
            .clk    (clk),
            .page   (page_reg),
            .left   (left_w),
            .ctrl   (ctrl_w[i]),
            .hit_in (hit_in_w),
            .entry  (entry_w[i]),
            .stat   (stat_w[i])
        );
    end

    assign hit = stat_w[MAX_FRAMES-1].hit_out;

    always_comb
    begin
        pos         = '0;
        bottom_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (stat_w[i].first)
            begin
                pos = pos | CNT_W'(i);
            end
            if (CNT_W'(i + 1) == count_reg)
            begin
                bottom_page = bottom_page | entry_w[i];
            end
        end
    end

    // A limit of zero acts as one; above the stack depth it acts as full depth.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (CMP_W'(cfg_reg) > CMP_W'(MAX_FRAMES))
        begin
            limit = CMP_W'(MAX_FRAMES);
        end
        else
        begin
            limit = CMP_W'(cfg_reg);
        end
    end

    assign evict     = !hit && (CMP_W'(count_reg) >= limit);
    assign cnt_kept  = evict ? (count_reg - CNT_W'(1)) : count_reg;
    assign shift_lim = hit ? pos : cnt_kept;

    always_comb
    begin
        act_next       = accept;
        done_next      = act_reg;
        page_next      = accept ? page_number : page_reg;
        cfg_next       = cfg_we ? cfg_data : cfg_reg;
        count_next     = count_reg;
        fault_cnt_next = fault_cnt_reg;
        fault_next     = fault_reg;
        depth_next     = depth_reg;
        evict_next     = evict_reg;
        ev_page_next   = ev_page_reg;
        if (act_reg)
        begin
            fault_next   = !hit;
            depth_next   = hit ? DEPTH_W'(pos) : '0;
            evict_next   = evict;
            ev_page_next = evict ? bottom_page : '0;
            if (!hit)
            begin
                count_next = cnt_kept + CNT_W'(1);
                if (fault_cnt_reg != FAULT_MAX)
                begin
                    fault_cnt_next = fault_cnt_reg + FAULT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            done_reg      <= 1'b0;
            cfg_reg       <= CFG_RESET;
            count_reg     <= '0;
            fault_cnt_reg <= '0;
        end
        else
        begin
            act_reg       <= act_next;
            done_reg      <= done_next;
            cfg_reg       <= cfg_next;
            count_reg     <= count_next;
            fault_cnt_reg <= fault_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        fault_reg   <= fault_next;
        depth_reg   <= depth_next;
        evict_reg   <= evict_next;
        ev_page_reg <= ev_page_next;
    end

    assign busy         = act_reg;
    assign done         = done_reg;
    assign page_fault   = fault_reg;
    assign hit_depth    = depth_reg;
    assign evict_valid  = evict_reg;
    assign evicted_page = ev_page_reg;
    assign occupancy    = OCC_W'(count_reg);
    assign fault_total  = fault_cnt_reg;

endmodule

// ----- hdl/lps_checker.sv -----
// Port-level assertions for the LRU page replacement stack.
// Watches only the top-level ports; bound to lru_page_replacement_stack.
// Depends on lps_pkg.
module lps_checker #(
    parameter int PAGE_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [PAGE_WIDTH-1:0]         page_number,
    input logic                          cfg_we,
    input logic [lps_pkg::CFG_W-1:0]     cfg_data,
    input logic                          done,
    input logic                          page_fault,
    input logic [lps_pkg::DEPTH_W-1:0]   hit_depth,
    input logic                          evict_valid,
    input logic [PAGE_WIDTH-1:0]         evicted_page,
    input logic [lps_pkg::OCC_W-1:0]     occupancy,
    input logic [lps_pkg::FAULT_W-1:0]   fault_total
);
    import lps_pkg::*;

    // A transfer on start is followed by exactly one busy cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 !busy)
        else $error("busy did not follow an accepted page for one cycle");

    // Every busy cycle leads straight to a result.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("no result after the compare/shift cycle");

    // A hit never evicts; an eviction only happens on a fault.
    a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done && evict_valid |-> page_fault)
        else $error("eviction reported on a hit");

    // On a fault the reported depth is zero.
    a_fault_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && page_fault |-> hit_depth == '0)
        else $error("nonzero hit depth on a fault");

    // A fault with nothing evicted shows a zero evicted page, nonzero occupancy and a nonzero total.
    a_fault_total: assert property (@(posedge clk) disable iff (!rst_n)
        done && page_fault && !evict_valid |-> evicted_page == '0 && occupancy != '0
            && fault_total != '0)
        else $error("fault result with inconsistent occupancy or total");

endmodule

bind lru_page_replacement_stack lps_checker #(
    .PAGE_WIDTH(PAGE_WIDTH)
) u_lps_checker (.*);
